[sv/cpuid_leaf_override_table_assert.svh]
// assertion macros for the cpuid leaf override table
// used by the top level; expects a clk and rst in scope at the point of use
`ifndef CPUID_LEAF_OVERRIDE_TABLE_ASSERT_SVH
`define CPUID_LEAF_OVERRIDE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked at every clock edge outside reset
`define CLOT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CLOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLOT_ASSERT_IMP(label, ante, cons, msg)
`define CLOT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/clot_pkg.sv]
// shared types and codes for the cpuid leaf override table
// no dependencies
package clot_pkg;

  localparam int TableEntriesDefault = 16;

  typedef logic [31:0]       word_t;
  typedef logic [3:0][31:0]  quad_t;

  // request kinds carried on s_tuser
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OUTSIDE = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOTFND  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    WR_CREATE,
    WR_MERGE,
    WR_REMOVE
  } wr_kind_t;

  // request held stable for the whole scan
  typedef struct packed {
    logic [1:0] kind;
    word_t      leaf;
    quad_t      mask;
    quad_t      data;
  } req_t;

  // partial result handed from cell to cell
  typedef struct packed {
    logic  token;
    logic  found;
    logic  overlap;
    logic  free_found;
    quad_t words;
  } scan_t;

  typedef struct packed {
    logic     en;
    wr_kind_t kind;
  } wr_t;

  function automatic word_t apply_word(word_t native, word_t m, word_t v);
    return (native & ~m) | (v & m);
  endfunction

  function automatic word_t merge_value(word_t v, word_t nm, word_t nv);
    return (v | nv) & (~nm | nv);
  endfunction

endpackage

[sv/clot_cell.sv]
// one table entry plus its stage of the search chain
// depends on clot_pkg
module clot_cell #(
  parameter int SlotW = 4,
  parameter int Index = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  clot_pkg::req_t      req,
  input  clot_pkg::scan_t     scan_in,
  input  logic [SlotW-1:0]    mslot_in,
  input  logic [SlotW-1:0]    fslot_in,
  output clot_pkg::scan_t     scan_out,
  output logic [SlotW-1:0]    mslot_out,
  output logic [SlotW-1:0]    fslot_out,
  input  clot_pkg::wr_t       wr,
  input  logic [SlotW-1:0]    wr_slot
);
  import clot_pkg::*;

  localparam logic [SlotW-1:0] MySlot = SlotW'(Index);

  logic  valid;
  word_t leaf;
  quad_t mask;
  quad_t value;

  scan_t            scan_next;
  logic [SlotW-1:0] mslot_next;
  logic [SlotW-1:0] fslot_next;
  logic             match;
  logic             overlap;
  logic             sel;

  assign match = scan_in.token && valid && (leaf == req.leaf) && !scan_in.found;
  assign overlap = |(mask & req.mask);
  assign sel = wr.en && (wr_slot == MySlot);

  always_comb begin
    scan_next  = scan_in;
    mslot_next = mslot_in;
    fslot_next = fslot_in;
    if (match) begin
      scan_next.found   = 1'b1;
      scan_next.overlap = overlap;
      mslot_next        = MySlot;
      for (int k = 0; k < 4; k++) begin
        scan_next.words[k] = apply_word(scan_in.words[k], mask[k], value[k]);
      end
    end
    if (scan_in.token && !valid && !scan_in.free_found) begin
      scan_next.free_found = 1'b1;
      fslot_next           = MySlot;
    end
  end

  // hand the partial result on
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.token <= 1'b0;
    end else begin
      scan_out.token <= scan_next.token;
    end
    scan_out.found      <= scan_next.found;
    scan_out.overlap    <= scan_next.overlap;
    scan_out.free_found <= scan_next.free_found;
    scan_out.words      <= scan_next.words;
    mslot_out           <= mslot_next;
    fslot_out           <= fslot_next;
  end

  // entry update from the write command
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      case (wr.kind)
        WR_CREATE: valid <= 1'b1;
        WR_REMOVE: valid <= 1'b0;
        default:   valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (wr.kind)
        WR_CREATE: begin
          leaf  <= req.leaf;
          mask  <= req.mask;
          value <= req.data;
        end
        WR_MERGE: begin
          for (int k = 0; k < 4; k++) begin
            mask[k]  <= mask[k] | req.mask[k];
            value[k] <= merge_value(value[k], req.mask[k], req.data[k]);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/cpuid_leaf_override_table.sv]
// cpuid leaf override table, top level
// depends on clot_pkg, clot_cell and cpuid_leaf_override_table_assert.svh
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: leaf and four mask/data pairs
// m_*       out  m_tvalid/m_tready  tuser: status, hit; tdata: eax..edx after override
//
// one request is in flight at a time; the request and a launch flag are registered
// on accept, the search token walks the row of entry cells one cell per cycle,
// the end of the search is registered, then the decision state decides and writes
// rst is synchronous and empties the table (valid bits only)
// a held result on m_* stalls the decision cycle; a new request is taken the cycle
// after the previous result is registered
module cpuid_leaf_override_table #(
  parameter int TABLE_ENTRIES = clot_pkg::TableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // [1:0] req_type
  input  logic [287:0] s_tdata,   // leaf, eax_mask, eax_data, ebx_mask, ebx_data,
                                  // ecx_mask, ecx_data, edx_mask, edx_data
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [3:0]   m_tuser,   // [2:0] status, [3] hit
  output logic [127:0] m_tdata    // eax_out, ebx_out, ecx_out, edx_out
);
  import clot_pkg::*;

  localparam int SlotW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  state_t state, state_next;
  logic   inject;
  req_t   req;

  // captured end of the search
  scan_t            res;
  logic [SlotW-1:0] res_mslot;
  logic [SlotW-1:0] res_fslot;

  // search chain taps
  scan_t            chain [0:TABLE_ENTRIES];
  logic [SlotW-1:0] mslot [0:TABLE_ENTRIES];
  logic [SlotW-1:0] fslot [0:TABLE_ENTRIES];

  wr_t              wr;
  logic [SlotW-1:0] wr_slot;
  logic [2:0]       status_d;
  logic             hit_d;
  quad_t            words_d;
  logic             advance;
  logic             outside;
  logic             s_accept;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign advance  = !m_tvalid || m_tready;

  // request register, loaded on the accepted transaction
  always_ff @(posedge clk) begin
    if (s_accept) begin
      req.kind <= s_tuser;
      req.leaf <= s_tdata[31:0];
      for (int k = 0; k < 4; k++) begin
        req.mask[k] <= s_tdata[32 + 64*k +: 32];
        req.data[k] <= s_tdata[64 + 64*k +: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inject <= 1'b0;
    end else begin
      inject <= s_accept;
    end
  end

  // head of the chain: native words, nothing found yet
  always_comb begin
    chain[0].token      = inject;
    chain[0].found      = 1'b0;
    chain[0].overlap    = 1'b0;
    chain[0].free_found = 1'b0;
    chain[0].words      = req.data;
    mslot[0]            = '0;
    fslot[0]            = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    clot_cell #(
      .SlotW (SlotW),
      .Index (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .scan_in   (chain[i]),
      .mslot_in  (mslot[i]),
      .fslot_in  (fslot[i]),
      .scan_out  (chain[i+1]),
      .mslot_out (mslot[i+1]),
      .fslot_out (fslot[i+1]),
      .wr        (wr),
      .wr_slot   (wr_slot)
    );
  end

  // token leaving the last cell carries the whole search result
  always_ff @(posedge clk) begin
    if (chain[TABLE_ENTRIES].token) begin
      res       <= chain[TABLE_ENTRIES];
      res_mslot <= mslot[TABLE_ENTRIES];
      res_fslot <= fslot[TABLE_ENTRIES];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_SCAN;
      S_SCAN:   if (chain[TABLE_ENTRIES].token) state_next = S_FINISH;
      S_FINISH: if (advance) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // any forced value bit not covered by its mask
  assign outside = |(req.data & ~req.mask);

  // decision: result fields and the entry write
  always_comb begin
    status_d = ST_OK;
    hit_d    = 1'b0;
    words_d  = '0;
    wr.en    = 1'b0;
    wr.kind  = WR_CREATE;
    wr_slot  = res_mslot;
    case (req.kind)
      REQ_ADD: begin
        hit_d = res.found;
        if (outside) begin
          status_d = ST_OUTSIDE;
        end else if (res.found) begin
          if (res.overlap) begin
            status_d = ST_OVERLAP;
          end else begin
            wr.en   = 1'b1;
            wr.kind = WR_MERGE;
          end
        end else if (res.free_found) begin
          wr.en   = 1'b1;
          wr.kind = WR_CREATE;
          wr_slot = res_fslot;
        end else begin
          status_d = ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        hit_d   = res.found;
        words_d = res.words;
      end
      REQ_REMOVE: begin
        if (res.found) begin
          hit_d   = 1'b1;
          wr.en   = 1'b1;
          wr.kind = WR_REMOVE;
        end else begin
          status_d = ST_NOTFND;
        end
      end
      default: begin
      end
    endcase
    // only commit when the result register can take the transaction
    if (!(state == S_FINISH && advance)) begin
      wr.en = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FINISH && advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && advance) begin
      m_tuser <= {hit_d, status_d};
      m_tdata <= words_d;
    end
  end

  `include "cpuid_leaf_override_table_assert.svh"

  // search token only travels while a request is being scanned
  `CLOT_ASSERT_IMP(a_token_in_scan, chain[TABLE_ENTRIES].token, state == S_SCAN, "token outside scan")
  // every accepted request launches a search token and enters the scan
  `CLOT_ASSERT_NEXT(a_inject_after_accept, s_accept, inject && state == S_SCAN, "no token after accept")
  // entry writes happen only in the decision cycle
  `CLOT_ASSERT_IMP(a_write_in_finish, wr.en, state == S_FINISH && advance, "stray entry write")
  // an overlap reject always refers to an existing entry
  `CLOT_ASSERT_IMP(a_overlap_hit, m_tvalid && m_tuser[2:0] == ST_OVERLAP, m_tuser[3], "overlap without hit")

endmodule
